// File: rtl/core/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants for the motion to scroll click converter.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

    localparam int STEP_W      = 6;
    localparam int ACC_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int DIR_W       = 2;
    localparam int CODE_W      = 3;

    localparam logic [STEP_W-1:0] STEP_MIN    = 6'd20;
    localparam logic [STEP_W-1:0] STEP_MAX    = 6'd38;
    localparam logic [STEP_W-1:0] STEP_RESET  = 6'd30;
    localparam logic [CODE_W-1:0] BUTTON_BASE = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VSTEP  = 2'd0,
        CFG_HSTEP  = 2'd1,
        CFG_INVERT = 2'd2
    } t_cfg_idx;

    typedef enum logic [DIR_W-1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_VERT,
        BK_HORIZ
    } t_back_state;

    // accumulator clears that go with a step rewrite
    typedef struct packed {
        logic vert;
        logic horiz;
    } t_acc_clr;

    function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        if (s < STEP_MIN) begin
            r = STEP_MIN;
        end else if (s > STEP_MAX) begin
            r = STEP_MAX;
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/scm_motion_if.sv
// ----------------------------------------------------------------------------
// scm_motion_if
// Valid/ready channel carrying one pair of signed motion deltas.
// ----------------------------------------------------------------------------
`default_nettype none

interface scm_motion_if #(
    parameter int DELTA_BITS = 10
);
    logic                         valid;
    logic                         ready;
    logic signed [DELTA_BITS-1:0] delta_x;
    logic signed [DELTA_BITS-1:0] delta_y;

    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scm_click_if.sv
// ----------------------------------------------------------------------------
// scm_click_if
// Valid/ready channel carrying one scroll click.
// ----------------------------------------------------------------------------
`default_nettype none

interface scm_click_if;
    logic       valid;
    logic       ready;
    logic [1:0] direction;
    logic [2:0] button_code;
    logic       last;

    modport source (output valid, output direction, output button_code, output last,
                    input ready);
    modport sink   (input valid, input direction, input button_code, input last,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/motion_to_scroll_clicks.sv
// ----------------------------------------------------------------------------
// motion_to_scroll_clicks
// Converts signed motion deltas into up/down/left/right scroll clicks.
//
//   channel   dir  handshake      payload
//   i_motion  in   valid/ready    delta_x, delta_y
//   o_click   out  valid/ready    direction, button_code, last
//   i_cfg_*   in   write enable   index, data
//
// The click engine pops an item while idle, then issues its vertical clicks and
// then its horizontal clicks, subtracting the axis step once per click. The front keeps
// taking items into a two-entry queue while the engine works.
// Output stalls hold the engine in place; a click waits in the output register.
// Synchronous active-low reset clears accumulators, queue, engine state, step settings and click valid.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_to_scroll_clicks #(
    parameter int DELTA_BITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [scm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [scm_pkg::STEP_W-1:0]    i_cfg_wdata,
    scm_motion_if.sink                         i_motion,
    scm_click_if.source                        o_click
);
    import scm_pkg::*;

    localparam int ITEM_W = 2 * DELTA_BITS;

    logic [STEP_W-1:0] r_vstep, n_vstep;
    logic [STEP_W-1:0] r_hstep, n_hstep;
    logic              r_inv, n_inv;
    t_acc_clr          clr;

    logic              push, full, q_valid, q_pop;
    logic [ITEM_W-1:0] push_item, q_item;

    always_comb begin
        n_vstep   = r_vstep;
        n_hstep   = r_hstep;
        n_inv     = r_inv;
        clr.vert  = 1'b0;
        clr.horiz = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VSTEP: begin
                    n_vstep  = i_cfg_wdata;
                    clr.vert = 1'b1;
                end
                CFG_HSTEP: begin
                    n_hstep   = i_cfg_wdata;
                    clr.horiz = 1'b1;
                end
                CFG_INVERT: begin
                    n_inv = i_cfg_wdata[0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vstep <= STEP_RESET;
            r_hstep <= STEP_RESET;
            r_inv   <= 1'b0;
        end else begin
            r_vstep <= n_vstep;
            r_hstep <= n_hstep;
            r_inv   <= n_inv;
        end
    end

    scm_front #(
        .DELTA_BITS (DELTA_BITS)
    ) u_front (
        .i_motion (i_motion),
        .i_full   (full),
        .o_push   (push),
        .o_item   (push_item)
    );

    scm_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    scm_back #(
        .DELTA_BITS (DELTA_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vstep   (clamp_step(r_vstep)),
        .i_hstep   (clamp_step(r_hstep)),
        .i_inv     (r_inv),
        .i_clr     (clr),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_click   (o_click)
    );

endmodule

`default_nettype wire

// File: rtl/core/scm_front.sv
// ----------------------------------------------------------------------------
// scm_front
// Takes motion transfers, saturates and splits each delta into sign and
// magnitude, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_front #(
    parameter int DELTA_BITS = 10
) (
    scm_motion_if.sink             i_motion,
    input  wire logic              i_full,
    output logic                   o_push,
    output logic [2*DELTA_BITS-1:0] o_item
);
    localparam int MAG_W = DELTA_BITS - 1;

    logic [MAG_W-1:0] ymag;
    logic [MAG_W-1:0] xmag;
    logic             ypos;
    logic             xpos;

    function automatic logic [DELTA_BITS-1:0] decode(input logic [DELTA_BITS-1:0] raw);
        logic [DELTA_BITS-1:0] neg;
        logic [MAG_W-1:0]      mag;
        logic                  pos;
        neg = ~raw + {{(DELTA_BITS-1){1'b0}}, 1'b1};
        if (raw[DELTA_BITS-1]) begin
            // most negative code has no positive twin: clip it
            if (raw[MAG_W-1:0] == '0) begin
                mag = '1;
            end else begin
                mag = neg[MAG_W-1:0];
            end
            pos = 1'b0;
        end else begin
            mag = raw[MAG_W-1:0];
            pos = (raw != '0);
        end
        return {pos, mag};
    endfunction

    assign {ypos, ymag} = decode(i_motion.delta_y);
    assign {xpos, xmag} = decode(i_motion.delta_x);

    assign i_motion.ready = !i_full;
    assign o_push         = i_motion.valid && !i_full;
    assign o_item         = {ypos, ymag, xpos, xmag};

endmodule

`default_nettype wire

// File: rtl/core/scm_fifo.sv
// ----------------------------------------------------------------------------
// scm_fifo
// Small register queue between the front and the click engine.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_fifo #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scm_back.sv
// ----------------------------------------------------------------------------
// scm_back
// Click engine: owns the four direction accumulators, pops one classified
// item, and subtracts the axis step once per click, vertical axis first.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_back #(
    parameter int DELTA_BITS = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [scm_pkg::STEP_W-1:0] i_vstep,
    input  wire logic [scm_pkg::STEP_W-1:0] i_hstep,
    input  wire logic                    i_inv,
    input  wire scm_pkg::t_acc_clr       i_clr,
    input  wire logic                    i_q_valid,
    input  wire logic [2*DELTA_BITS-1:0] i_q_item,
    output logic                         o_q_pop,
    scm_click_if.source                  o_click
);
    import scm_pkg::*;

    localparam int MAG_W = DELTA_BITS - 1;
    localparam int TOT_W = ((MAG_W > ACC_W) ? MAG_W : ACC_W) + 1;

    t_back_state r_state, n_state;

    logic [ACC_W-1:0] r_up, n_up, r_down, n_down, r_left, n_left, r_right, n_right;
    logic [TOT_W-1:0] r_vtot, n_vtot, r_htot, n_htot;
    logic             r_ypos, n_ypos, r_xpos, n_xpos;
    logic             r_out_valid, n_out_valid;
    logic [DIR_W-1:0] r_out_dir, n_out_dir;
    logic [CODE_W-1:0] r_out_code, n_out_code;
    logic             r_out_last, n_out_last;

    logic [MAG_W-1:0] q_ymag, q_xmag;
    logic             q_ypos, q_xpos;
    logic [TOT_W-1:0] vs_ext, hs_ext, v_rem, h_rem;
    logic             v_click, h_click, out_free;
    logic [ACC_W-1:0] v_acc, h_acc;
    t_dir             v_dir, h_dir;

    assign {q_ypos, q_ymag, q_xpos, q_xmag} = i_q_item;

    assign vs_ext   = {{(TOT_W-STEP_W){1'b0}}, i_vstep};
    assign hs_ext   = {{(TOT_W-STEP_W){1'b0}}, i_hstep};
    assign v_rem    = r_vtot - vs_ext;
    assign h_rem    = r_htot - hs_ext;
    assign v_click  = (r_vtot >= vs_ext);
    assign h_click  = (r_htot >= hs_ext);
    assign out_free = !r_out_valid || o_click.ready;
    assign v_acc    = q_ypos ? r_down : r_up;
    assign h_acc    = q_xpos ? r_right : r_left;
    assign v_dir    = r_ypos ? DIR_DOWN : DIR_UP;
    assign h_dir    = r_xpos ? DIR_RIGHT : DIR_LEFT;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) n_state = BK_VERT;
            end
            BK_VERT: begin
                if (!v_click) n_state = BK_HORIZ;
            end
            BK_HORIZ: begin
                if (!h_click) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        n_up        = r_up;
        n_down      = r_down;
        n_left      = r_left;
        n_right     = r_right;
        n_vtot      = r_vtot;
        n_htot      = r_htot;
        n_ypos      = r_ypos;
        n_xpos      = r_xpos;
        n_out_valid = r_out_valid && !o_click.ready;
        n_out_dir   = r_out_dir;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_ypos  = q_ypos;
                    n_xpos  = q_xpos;
                    n_vtot  = {{(TOT_W-ACC_W){1'b0}}, v_acc}
                            + {{(TOT_W-MAG_W){1'b0}}, q_ymag};
                    n_htot  = {{(TOT_W-ACC_W){1'b0}}, h_acc}
                            + {{(TOT_W-MAG_W){1'b0}}, q_xmag};
                end
            end
            BK_VERT: begin
                if (v_click) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_dir   = v_dir;
                        n_out_code  = BUTTON_BASE + {1'b0, v_dir ^ {1'b0, i_inv}};
                        n_out_last  = (v_rem < vs_ext) && !h_click;
                        n_vtot      = v_rem;
                    end
                end else if (r_ypos) begin
                    n_down = r_vtot[ACC_W-1:0];
                end else begin
                    n_up = r_vtot[ACC_W-1:0];
                end
            end
            BK_HORIZ: begin
                if (h_click) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_dir   = h_dir;
                        n_out_code  = BUTTON_BASE + {1'b0, h_dir ^ {1'b0, i_inv}};
                        n_out_last  = (h_rem < hs_ext);
                        n_htot      = h_rem;
                    end
                end else if (r_xpos) begin
                    n_right = r_htot[ACC_W-1:0];
                end else begin
                    n_left = r_htot[ACC_W-1:0];
                end
            end
            default: ;
        endcase
        // the user must rewrite steps only while the engine is idle; the block does not enforce it
        if (i_clr.vert) begin
            n_up   = '0;
            n_down = '0;
        end
        if (i_clr.horiz) begin
            n_left  = '0;
            n_right = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_up        <= '0;
            r_down      <= '0;
            r_left      <= '0;
            r_right     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_up        <= n_up;
            r_down      <= n_down;
            r_left      <= n_left;
            r_right     <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtot     <= n_vtot;
        r_htot     <= n_htot;
        r_ypos     <= n_ypos;
        r_xpos     <= n_xpos;
        r_out_dir  <= n_out_dir;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_click.valid       = r_out_valid;
    assign o_click.direction   = r_out_dir;
    assign o_click.button_code = r_out_code;
    assign o_click.last        = r_out_last;

endmodule

`default_nettype wire

// File: test/scm_click_checker.sv
// ----------------------------------------------------------------------------
// scm_click_checker
// Watches the motion, click and register-write ports of the scroll click
// converter. Keeps its own copy of the step registers and the four direction
// accumulators, expands every accepted motion transfer into the clicks it
// must cause, and compares each accepted click field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_click_checker #(
    parameter int DELTA_BITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [scm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [scm_pkg::STEP_W-1:0]    i_cfg_wdata,
    scm_motion_if                              i_motion,
    scm_click_if                               i_click,
    output int                                 o_fail_count,
    output int                                 o_clicks_pending
);
    import scm_pkg::*;

    // largest magnitude a delta can carry once the most negative code saturates
    localparam int MAG_MAX = 2 ** (DELTA_BITS - 1) - 1;

    typedef struct packed {
        t_dir              direction;
        logic [CODE_W-1:0] button_code;
        logic              last;
    } t_scroll_click;

    t_scroll_click     clicks_due[$];
    logic [STEP_W-1:0] vstep_raw;
    logic [STEP_W-1:0] hstep_raw;
    logic              invert_on;
    logic [ACC_W-1:0]  accum [4];
    int                fail_total;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_total++;
    endtask

    function automatic int step_in_use(input logic [STEP_W-1:0] raw);
        if (raw < STEP_MIN) begin
            return int'(STEP_MIN);
        end
        if (raw > STEP_MAX) begin
            return int'(STEP_MAX);
        end
        return int'(raw);
    endfunction

    // one axis: pick the accumulator by sign, then peel off whole steps
    task automatic feed_axis(input int delta, input int step,
                             input t_dir pos_dir, input t_dir neg_dir);
        t_dir             dir;
        int               mag;
        int               total;
        logic [DIR_W-1:0] mapped;
        t_scroll_click    click;
        if (delta > 0) begin
            dir = pos_dir;
            mag = delta;
        end else begin
            dir = neg_dir;
            mag = (-delta > MAG_MAX) ? MAG_MAX : -delta;
        end
        mapped = dir ^ {{(DIR_W - 1){1'b0}}, invert_on};
        total  = int'(accum[dir]) + mag;
        while (total >= step) begin
            total             -= step;
            click.direction    = dir;
            click.button_code  = BUTTON_BASE + {1'b0, mapped};
            click.last         = 1'b0;
            clicks_due.push_back(click);
        end
        accum[dir] = total[ACC_W-1:0];
    endtask

    task automatic predict_clicks(input int dx, input int dy);
        int            count_before;
        t_scroll_click tail;
        count_before = clicks_due.size();
        feed_axis(dy, step_in_use(vstep_raw), DIR_DOWN, DIR_UP);
        feed_axis(dx, step_in_use(hstep_raw), DIR_RIGHT, DIR_LEFT);
        if (clicks_due.size() > count_before) begin
            tail      = clicks_due.pop_back();
            tail.last = 1'b1;
            clicks_due.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        t_scroll_click want;
        if (!i_rst_n) begin
            vstep_raw  = STEP_RESET;
            hstep_raw  = STEP_RESET;
            invert_on  = 1'b0;
            fail_total = 0;
            foreach (accum[i]) begin
                accum[i] = '0;
            end
            clicks_due.delete();
        end else begin
            // a click transfer always belongs to an earlier motion transfer
            if (i_click.valid && i_click.ready) begin
                if (clicks_due.size() == 0) begin
                    report($sformatf("unexpected click: dir %0d code %0d last %0d",
                                     i_click.direction, i_click.button_code,
                                     i_click.last));
                end else begin
                    want = clicks_due.pop_front();
                    if (i_click.direction !== want.direction) begin
                        report($sformatf("direction: got %0d, want %0d",
                                         i_click.direction, want.direction));
                    end
                    if (i_click.button_code !== want.button_code) begin
                        report($sformatf("button_code: got %0d, want %0d",
                                         i_click.button_code, want.button_code));
                    end
                    if (i_click.last !== want.last) begin
                        report($sformatf("last: got %0d, want %0d",
                                         i_click.last, want.last));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VSTEP: begin
                        vstep_raw        = i_cfg_wdata;
                        accum[DIR_UP]    = '0;
                        accum[DIR_DOWN]  = '0;
                    end
                    CFG_HSTEP: begin
                        hstep_raw        = i_cfg_wdata;
                        accum[DIR_LEFT]  = '0;
                        accum[DIR_RIGHT] = '0;
                    end
                    CFG_INVERT: begin
                        invert_on = i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_motion.valid && i_motion.ready) begin
                predict_clicks(int'(i_motion.delta_x), int'(i_motion.delta_y));
            end
        end
        o_clicks_pending <= clicks_due.size();
        o_fail_count     <= fail_total;
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for motion_to_scroll_clicks. After reset a directed
// set of deltas covers the extremes, the saturated most negative code, exact
// step hits and zero-click items. Then several register settings follow,
// including out-of-range steps and an unused register index, each with a
// batch of random deltas. The sender works in bursts, the receiver stalls
// on its own pattern, and the checker does all prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import scm_pkg::*;

    localparam int          DELTA_BITS     = 10;
    localparam int          MAG_MAX        = 2 ** (DELTA_BITS - 1) - 1;
    localparam int          ITEMS_PER_SET  = 77;
    localparam int          SETTLE_CYCLES  = 32;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [2:0] WR_VSTEP  = 3'b001;
    localparam logic [2:0] WR_HSTEP  = 3'b010;
    localparam logic [2:0] WR_INVERT = 3'b100;
    localparam logic [2:0] WR_ALL    = 3'b111;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [STEP_W-1:0]    cfg_wdata;
    int                   fail_count;
    int                   clicks_pending;
    int unsigned          cycle_cnt = 0;
    int                   burst_left = 0;
    logic                 gapless = 1'b0;

    scm_motion_if #(.DELTA_BITS(DELTA_BITS)) motion_ch ();
    scm_click_if                             click_ch ();

    motion_to_scroll_clicks #(
        .DELTA_BITS (DELTA_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_motion    (motion_ch),
        .o_click     (click_ch)
    );

    scm_click_checker #(
        .DELTA_BITS (DELTA_BITS)
    ) checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_wdata      (cfg_wdata),
        .i_motion         (motion_ch),
        .i_click          (click_ch),
        .o_fail_count     (fail_count),
        .o_clicks_pending (clicks_pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("motion_to_scroll_clicks test failed");
            $finish;
        end
    end

    // receiver: switches between free flow, light, heavy and choppy stalls
    initial begin
        int stall_mode;
        int run_left;
        stall_mode     = 0;
        run_left       = 0;
        click_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (run_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                run_left   = $urandom_range(20, 200);
            end
            run_left--;
            case (stall_mode)
                0:       click_ch.ready <= 1'b1;
                1:       click_ch.ready <= ($urandom_range(0, 7) != 0);
                2:       click_ch.ready <= ($urandom_range(0, 1) != 0);
                default: click_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    function automatic logic [DELTA_BITS-1:0] pick_delta();
        logic [DELTA_BITS-1:0] raw;
        int                    sel;
        sel = $urandom_range(0, 99);
        raw = DELTA_BITS'($urandom);
        if (sel < 55) begin
            raw = DELTA_BITS'(int'($urandom_range(0, 120)) - 60);
        end else if (sel < 88) begin
            case ($urandom_range(0, 5))
                0:       raw = DELTA_BITS'(-MAG_MAX - 1);
                1:       raw = DELTA_BITS'(-MAG_MAX);
                2:       raw = DELTA_BITS'(MAG_MAX);
                3:       raw = '0;
                4:       raw = DELTA_BITS'(1);
                default: raw = '1;
            endcase
        end
        return raw;
    endfunction

    task automatic send_motion(input int dx, input int dy);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = gapless ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                motion_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        motion_ch.valid   <= 1'b1;
        motion_ch.delta_x <= DELTA_BITS'(dx);
        motion_ch.delta_y <= DELTA_BITS'(dy);
        @(posedge clk);
        while (!motion_ch.ready) begin
            @(posedge clk);
        end
    endtask

    // zero-click items may still sit in the engine once no click is owed
    task automatic wait_engine_idle();
        motion_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (clicks_pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [STEP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_setting(input logic [STEP_W-1:0] vstep,
                               input logic [STEP_W-1:0] hstep,
                               input logic inv, input logic [2:0] wr_mask);
        logic [STEP_W-1:0] inv_word;
        wait_engine_idle();
        inv_word    = STEP_W'($urandom);
        inv_word[0] = inv;
        if (wr_mask & WR_VSTEP) begin
            write_reg(CFG_VSTEP, vstep);
        end
        if (wr_mask & WR_HSTEP) begin
            write_reg(CFG_HSTEP, hstep);
        end
        if (wr_mask & WR_INVERT) begin
            write_reg(CFG_INVERT, inv_word);
        end
        write_reg(CFG_UNUSED, STEP_W'($urandom));
        gapless = ($urandom_range(0, 3) == 0);
        repeat (ITEMS_PER_SET) begin
            send_motion(int'(pick_delta()), int'(pick_delta()));
        end
    endtask

    initial begin
        motion_ch.valid   = 1'b0;
        motion_ch.delta_x = '0;
        motion_ch.delta_y = '0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_VSTEP;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, saturation, exact step hits, no-click items
        send_motion(0, 0);
        send_motion(1, -1);
        send_motion(-1, -1);
        send_motion(0, -1);
        send_motion(MAG_MAX, 0);
        send_motion(0, MAG_MAX);
        send_motion(-MAG_MAX, 0);
        send_motion(0, -MAG_MAX);
        send_motion(-MAG_MAX - 1, -MAG_MAX - 1);
        send_motion(MAG_MAX, MAG_MAX);
        send_motion(-MAG_MAX - 1, MAG_MAX);
        send_motion(MAG_MAX, -MAG_MAX - 1);
        send_motion(29, 29);
        send_motion(1, 1);
        send_motion(30, -30);
        send_motion(-29, -29);
        send_motion(-1, -1);
        send_motion(341, -342);
        send_motion(-342, 341);
        send_motion(59, 60);
        send_motion(-60, -59);

        run_setting(6'd20, 6'd38, 1'b1, WR_ALL);
        run_setting(6'd38, 6'd20, 1'b0, WR_ALL);
        run_setting(6'd0, 6'd63, 1'b1, WR_ALL);
        run_setting(6'd19, 6'd39, 1'b0, WR_VSTEP | WR_HSTEP);
        run_setting(6'd0, 6'd0, 1'b1, WR_INVERT);
        run_setting(STEP_W'($urandom_range(20, 38)), STEP_W'($urandom_range(20, 38)),
                    ($urandom_range(0, 1) != 0), WR_ALL);

        wait_engine_idle();
        if (fail_count == 0) begin
            $display("motion_to_scroll_clicks test passed");
        end else begin
            $display("motion_to_scroll_clicks test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
